### rtl/core/keyword_identifier_classifier_macros.svh
// Assertion macros for the keyword and identifier classifier.
// Expects aclk and aresetn in the including module; no other dependencies.
`ifndef KEYWORD_IDENTIFIER_CLASSIFIER_MACROS_SVH
`define KEYWORD_IDENTIFIER_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define KIC_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define KIC_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/kic_pkg.sv
// Shared types, keyword table and character helpers for the keyword classifier.
// No dependencies.
package kic_pkg;

    localparam int TABLE_SIZE      = 22;
    localparam int KW_CHARS        = 12;
    localparam int DEF_KEYWORD_COUNT = 22;
    localparam int DEF_ORDINAL_MAX = 1023;
    localparam int ORD_W           = 10;
    localparam int IDX_W           = 5;
    localparam int POS_W           = 4;

    localparam logic [POS_W-1:0] POS_MAX = 4'd15;
    localparam logic [7:0]       CHAR_SPACE = 8'h20;

    // Word class codes
    localparam logic [1:0] CLASS_RESERVED = 2'd0;
    localparam logic [1:0] CLASS_IDENT    = 2'd1;
    localparam logic [1:0] CLASS_NONE     = 2'd2;

    // Keyword text, right-justified: first character in the highest used byte
    localparam logic [8*KW_CHARS-1:0] KW_TEXT [TABLE_SIZE] = '{
        96'("SI"), 96'("FIN-SI"), 96'("SINO"), 96'("PARA"), 96'("DESDE"),
        96'("HASTA"), 96'("INCREMENTO"), 96'("FIN-PARA"), 96'("REPETIR"),
        96'("MIENTRAS"), 96'("FIN-MIENTRAS"), 96'("salida->"),
        96'("entrada->"), 96'("verdad"), 96'("falso"), 96'("sqrt"),
        96'("int"), 96'("char"), 96'("strring"), 96'("booleano"),
        96'("float"), 96'("double")
    };

    localparam logic [POS_W-1:0] KW_LEN [TABLE_SIZE] = '{
        4'd2, 4'd6, 4'd4, 4'd4, 4'd5, 4'd5, 4'd10, 4'd8, 4'd7, 4'd8, 4'd12,
        4'd8, 4'd9, 4'd6, 4'd5, 4'd4, 4'd3, 4'd4, 4'd7, 4'd8, 4'd5, 4'd6
    };

    // Summary of the pending word, from the tracker to the classifier
    typedef struct packed {
        logic             close;
        logic             open;
        logic             is_kw;
        logic             is_ident;
        logic [IDX_W-1:0] kw_index;
    } kic_word_t;

    // One result
    typedef struct packed {
        logic [1:0]       word_class;
        logic [IDX_W-1:0] keyword_index;
        logic [ORD_W-1:0] class_ordinal;
    } kic_result_t;

    // Character of keyword k at position p; zero past its end
    function automatic logic [7:0] kw_byte(input int k, input logic [POS_W-1:0] p);
        logic [8*KW_CHARS-1:0] txt;
        int                    sh;
        txt = KW_TEXT[k];
        sh  = 8 * (int'(KW_LEN[k]) - 1 - int'(p));
        if (sh < 0) begin
            kw_byte = 8'h00;
        end else begin
            kw_byte = txt[sh +: 8];
        end
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        is_letter = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

### rtl/core/kic_word_track.sv
// Per-word tracking: parallel keyword prefix match, length and identifier state.
// Depends on kic_pkg and keyword_identifier_classifier_macros.svh.
`include "keyword_identifier_classifier_macros.svh"

module kic_word_track #(
    parameter int KEYWORD_COUNT = kic_pkg::DEF_KEYWORD_COUNT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output kic_pkg::kic_word_t word
);
    import kic_pkg::*;

    localparam int KW_USED = (KEYWORD_COUNT < TABLE_SIZE) ? KEYWORD_COUNT : TABLE_SIZE;

    // Identifier scan states
    localparam logic [1:0] ST_START = 2'd0;
    localparam logic [1:0] ST_IDENT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    logic [KW_USED-1:0] alive_reg, alive_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [1:0]         ident_reg, ident_next;
    logic               close;
    logic               found;
    logic [IDX_W-1:0]   found_idx;

    assign close = in_last || (in_byte == CHAR_SPACE);

    // Find the keyword that the word matches exactly, lowest index first
    always_comb begin
        found     = 1'b0;
        found_idx = '0;
        for (int k = 0; k < KW_USED; k++) begin
            if (!found && alive_reg[k] && (KW_LEN[k] == pos_reg)) begin
                found     = 1'b1;
                found_idx = IDX_W'(k);
            end
        end
    end

    assign word.close    = close;
    assign word.open     = (ident_reg != ST_START);
    assign word.is_kw    = found;
    assign word.is_ident = (ident_reg == ST_IDENT);
    assign word.kw_index = found_idx;

    // Advance the word state on a character, clear it on a word break
    always_comb begin
        alive_next = alive_reg;
        pos_next   = pos_reg;
        ident_next = ident_reg;
        if (take) begin
            if (close) begin
                alive_next = '1;
                pos_next   = '0;
                ident_next = ST_START;
            end else begin
                for (int k = 0; k < KW_USED; k++) begin
                    alive_next[k] = alive_reg[k] && (pos_reg < KW_LEN[k])
                                    && (kw_byte(k, pos_reg) == in_byte);
                end
                pos_next = (pos_reg < POS_MAX) ? pos_reg + 1'b1 : POS_MAX;
                case (ident_reg)
                    ST_START: ident_next = is_letter(in_byte) ? ST_IDENT : ST_BAD;
                    ST_IDENT: ident_next = (is_letter(in_byte) || is_digit(in_byte))
                                           ? ST_IDENT : ST_BAD;
                    default:  ident_next = ST_BAD;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '1;
            pos_reg   <= '0;
            ident_reg <= ST_START;
        end else begin
            alive_reg <= alive_next;
            pos_reg   <= pos_next;
            ident_reg <= ident_next;
        end
    end

    `KIC_ASSERT_NEXT(a_break_clears, take && close, pos_reg == '0 && ident_reg == ST_START, "word state not cleared after break")
    `KIC_ASSERT_NOW(a_empty_is_short, ident_reg == ST_START, pos_reg == '0, "empty word with non-zero length")
    `KIC_ASSERT_NEXT(a_char_opens, take && !close, ident_reg != ST_START, "character left the word empty")

endmodule

### rtl/core/kic_classify.sv
// Word classification and saturating per-class ordinals.
// Depends on kic_pkg.
module kic_classify #(
    parameter int ORDINAL_MAX = kic_pkg::DEF_ORDINAL_MAX
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 take,
    input  kic_pkg::kic_word_t   word,
    output logic                 emit,
    output kic_pkg::kic_result_t result
);
    import kic_pkg::*;

    localparam int TOT_W = $clog2(ORDINAL_MAX + 1);
    localparam logic [TOT_W-1:0] TOT_MAX = TOT_W'(ORDINAL_MAX);

    logic [TOT_W-1:0] rsv_tot_reg, rsv_tot_next;
    logic [TOT_W-1:0] id_tot_reg, id_tot_next;
    logic [TOT_W-1:0] rsv_inc, id_inc;

    assign emit    = take && word.close && word.open;
    assign rsv_inc = (rsv_tot_reg >= TOT_MAX) ? TOT_MAX : rsv_tot_reg + 1'b1;
    assign id_inc  = (id_tot_reg >= TOT_MAX) ? TOT_MAX : id_tot_reg + 1'b1;

    // Pick the class; reserved words take precedence over identifiers
    always_comb begin
        rsv_tot_next = rsv_tot_reg;
        id_tot_next  = id_tot_reg;
        result.word_class    = CLASS_NONE;
        result.keyword_index = '0;
        result.class_ordinal = '0;
        if (word.is_kw) begin
            result.word_class    = CLASS_RESERVED;
            result.keyword_index = word.kw_index;
            result.class_ordinal = ORD_W'(rsv_inc);
            if (emit) begin
                rsv_tot_next = rsv_inc;
            end
        end else if (word.is_ident) begin
            result.word_class    = CLASS_IDENT;
            result.class_ordinal = ORD_W'(id_inc);
            if (emit) begin
                id_tot_next = id_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsv_tot_reg <= '0;
            id_tot_reg  <= '0;
        end else begin
            rsv_tot_reg <= rsv_tot_next;
            id_tot_reg  <= id_tot_next;
        end
    end

endmodule

### rtl/core/keyword_identifier_classifier.sv
// Keyword and identifier classifier, top level with the result register.
// A result is registered on m_ in the cycle after the request that closes its word.
// One request per cycle unless a result is stalled downstream; the keyword match
// and class update are combinational. Synchronous active-low reset clears the
// word state, both ordinal counters and the result valid flag; depends on kic_pkg and submodules.
`include "keyword_identifier_classifier_macros.svh"

module keyword_identifier_classifier #(
    parameter int KEYWORD_COUNT = kic_pkg::DEF_KEYWORD_COUNT,
    parameter int ORDINAL_MAX   = kic_pkg::DEF_ORDINAL_MAX
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] keyword_index, [14:5] class_ordinal, [15] zero
    output logic [1:0]  m_tuser    // [1:0] word_class
);
    import kic_pkg::*;

    logic        take;
    logic        emit;
    kic_word_t   word;
    kic_result_t result;
    logic        out_valid_reg, out_valid_next;
    kic_result_t out_reg;

    // Accept whenever the result register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    kic_word_track #(
        .KEYWORD_COUNT(KEYWORD_COUNT)
    ) u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .word    (word)
    );

    kic_classify #(
        .ORDINAL_MAX(ORDINAL_MAX)
    ) u_class (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .word    (word),
        .emit    (emit),
        .result  (result)
    );

    // Load a new result or drop the one taken downstream
    always_comb begin
        out_valid_next = out_valid_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.class_ordinal, out_reg.keyword_index};
    assign m_tuser  = out_reg.word_class;

    `KIC_ASSERT_NOW(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready, "request taken while result stalled")
    `KIC_ASSERT_NOW(a_none_zero, m_tvalid && m_tuser == CLASS_NONE, m_tdata == 16'h0000, "neither class with non-zero fields")
    `KIC_ASSERT_NOW(a_ident_fields, m_tvalid && m_tuser == CLASS_IDENT, m_tdata[4:0] == '0 && m_tdata[14:5] != '0, "identifier with bad index or ordinal")
    `KIC_ASSERT_NOW(a_class_code, m_tvalid, m_tuser != 2'd3, "unused class code on output")

endmodule
